// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ffua_pkg.sv -----
// Types and constants for the first-fit unit allocator.
`default_nettype none

package ffua_pkg;

	// fixed field widths of the request, response and config words
	localparam int OP_W     = 1;
	localparam int SIZE_W   = 11;
	localparam int OWNER_W  = 10;
	localparam int START_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int CFG_W    = 11;

	// units managed after reset
	localparam logic [CFG_W-1:0] UNITS_RESET = 11'd1024;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	// response status codes
	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_FREED     = 2'd2,
		ST_BAD       = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/ffua_ifs.sv -----
// Request, response and config channel interfaces of the allocator.
`default_nettype none

// request words: operation, size and owner
interface ffua_req_if;
	logic                          valid;
	logic                          ready;
	logic [ffua_pkg::OP_W-1:0]     operation;
	logic [ffua_pkg::SIZE_W-1:0]   alloc_size;
	logic [ffua_pkg::OWNER_W-1:0]  owner_id;

	modport source (output valid, output operation, output alloc_size, output owner_id,
		input ready);
	modport sink (input valid, input operation, input alloc_size, input owner_id,
		output ready);
endinterface

// response words: status, block start and freed count
interface ffua_rsp_if;
	logic                          valid;
	logic                          ready;
	ffua_pkg::status_t             status;
	logic [ffua_pkg::START_W-1:0]  start_index;
	logic [ffua_pkg::COUNT_W-1:0]  freed_count;

	modport source (output valid, output status, output start_index, output freed_count,
		input ready);
	modport sink (input valid, input status, input start_index, input freed_count,
		output ready);
endinterface

// config write words: units in use
interface ffua_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ffua_pkg::CFG_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/first_fit_unit_allocator.sv -----
// Response path: a bad request (owner id zero), an empty range or a zero size goes straight to the
// response register; a free scans the units in use; an allocation scans up to the last unit of the
// block, then tags the block in a fill pass, and one with no fit scans all units in use.
// Flow: one request at a time; ready returns the cycle after the response is loaded, and the
// response waits while the output register is still full. The single owner memory is read once
// and written once per cycle. Reset: asynchronous, active low; a clearing pass zeroes the owner
// memory, during which no request is taken (config writes are still accepted).
`default_nettype none
`include "assert_macros.svh"

module first_fit_unit_allocator #(
	parameter int UNITS   = 1024,
	parameter int ID_BITS = 10
) (
	input  wire            clk,
	input  wire            arst_n,
	ffua_req_if.sink       req,
	ffua_rsp_if.source     rsp,
	ffua_cfg_if.sink       cfg
);
	import ffua_pkg::*;

	localparam int IW  = $clog2(UNITS);
	localparam int NW  = $clog2(UNITS + 1);
	localparam int CW  = (NW > CFG_W) ? NW : CFG_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_FILL,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    units_q;
	logic [ID_BITS-1:0]  id_q;
	logic [CW-1:0]       size_q;
	logic [IW-1:0]       pos_q;
	logic [IW-1:0]       fill_q;
	logic [IW-1:0]       end_q;
	logic [IW-1:0]       start_q;
	logic [CW-1:0]       run_q;
	logic [CW-1:0]       cnt_q;
	status_t             status_q;

	// owner memory
	logic [ID_BITS-1:0]  mem [UNITS];
	logic [ID_BITS-1:0]  rdata_q;
	logic [IW-1:0]       raddr;
	logic [IW-1:0]       waddr;
	logic [ID_BITS-1:0]  wdata;
	logic                we;

	logic [CW-1:0]       n_units;
	logic                last_pos;
	logic [CW-1:0]       run_nx;
	logic                req_acc;
	logic [ID_BITS-1:0]  req_id;
	logic [CW-1:0]       req_size;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign req_id    = ID_BITS'(req.owner_id);
	assign req_size  = CW'(req.alloc_size);

	// managed range, saturated to the memory depth
	assign n_units  = (CW'(units_q) > CW'(UNITS)) ? CW'(UNITS) : CW'(units_q);
	assign last_pos = (CW'(pos_q) == (n_units - CW'(1)));
	assign run_nx   = run_q + CW'(1);

	// memory port control
	always_comb begin
		raddr = pos_q + IW'(1);
		we    = 1'b0;
		waddr = pos_q;
		wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				raddr = '0;
			end
			S_FREE: begin
				we = (rdata_q == id_q);
			end
			S_FILL: begin
				we    = 1'b1;
				waddr = fill_q;
				wdata = id_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// sequencer with registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			units_q         <= UNITS_RESET;
			pos_q           <= '0;
			run_q           <= '0;
			cnt_q           <= '0;
			start_q         <= '0;
			fill_q          <= '0;
			end_q           <= '0;
			size_q          <= '0;
			id_q            <= '0;
			status_q        <= ST_BAD;
			rsp.valid       <= 1'b0;
			rsp.status      <= ST_BAD;
			rsp.start_index <= '0;
			rsp.freed_count <= '0;
		end else begin
			if (cfg.valid && cfg.ready)
				units_q <= cfg.data;
			// in S_DONE the response load below owns the valid flag
			if (rsp.valid && rsp.ready && state_q != S_DONE)
				rsp.valid <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == IW'(UNITS - 1)) begin
						pos_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						pos_q <= pos_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						id_q    <= req_id;
						size_q  <= req_size;
						pos_q   <= '0;
						run_q   <= '0;
						cnt_q   <= '0;
						start_q <= '0;
						priority if (req_id == '0) begin
							status_q <= ST_BAD;
							state_q  <= S_DONE;
						end else if (req.operation == OP_ALLOC) begin
							status_q <= ST_NO_FIT;
							if (req_size == '0 || n_units == '0)
								state_q <= S_DONE;
							else
								state_q <= S_ALLOC;
						end else begin
							status_q <= ST_FREED;
							if (n_units == '0)
								state_q <= S_DONE;
							else
								state_q <= S_FREE;
						end
					end
				end
				S_ALLOC: begin
					pos_q <= pos_q + IW'(1);
					if (rdata_q != '0) begin
						run_q <= '0;
						if (last_pos)
							state_q <= S_DONE;
					end else if (run_nx == size_q) begin
						// run complete: tag it in a fill pass
						start_q  <= pos_q + IW'(1) - IW'(size_q);
						fill_q   <= pos_q + IW'(1) - IW'(size_q);
						end_q    <= pos_q;
						status_q <= ST_ALLOCATED;
						state_q  <= S_FILL;
					end else begin
						run_q <= run_nx;
						if (last_pos)
							state_q <= S_DONE;
					end
				end
				S_FREE: begin
					pos_q <= pos_q + IW'(1);
					if (rdata_q == id_q)
						cnt_q <= cnt_q + CW'(1);
					if (last_pos)
						state_q <= S_DONE;
				end
				S_FILL: begin
					fill_q <= fill_q + IW'(1);
					if (fill_q == end_q)
						state_q <= S_DONE;
				end
				S_DONE: begin
					// wait for the output register to be free
					if (!rsp.valid || rsp.ready) begin
						rsp.valid       <= 1'b1;
						rsp.status      <= status_q;
						rsp.start_index <= START_W'(start_q);
						rsp.freed_count <= COUNT_W'(cnt_q);
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`ASSERT_CLK(a_no_write_idle, clk, arst_n, (state_q == S_IDLE) |-> !we, "write while idle")
	`ASSERT_CLK(a_no_req_clear, clk, arst_n, (state_q == S_CLEAR) |-> !req.ready, "req in clear")
	`ASSERT_CLK(a_fill_bound, clk, arst_n, (state_q == S_FILL) |-> (fill_q <= end_q), "fill over")
	`ASSERT_CLK(a_cnt_bound, clk, arst_n, (state_q == S_FREE) |-> (cnt_q <= CW'(pos_q)), "count")

endmodule

`default_nettype wire
